/* rtl/slr_pkg.sv */
// Shared types and constants for the stopwatch lap recorder.
// No dependencies; used by every file under rtl.
package slr_pkg;

    localparam int LAP_SLOTS_DEFAULT = 16;

    localparam logic [15:0] LAP_COUNT_MAX = 16'hFFFF;

    // command codes; unused codes behave as read only
    localparam logic [2:0] KIND_START  = 3'd0;
    localparam logic [2:0] KIND_PAUSE  = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_LAP    = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    typedef enum logic [1:0] {
        MODE_CLEARED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ticks;
        logic [7:0]  lap_back;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  run_state;
        logic [31:0] elapsed;
        logic [15:0] laps_recorded;
        logic        lap_valid;
        logic [15:0] lap_number;
        logic [31:0] lap_time;
    } out_item_t;

    typedef struct packed {
        logic [31:0] lap_time;
        logic [15:0] lap_number;
    } lap_entry_t;

endpackage

/* rtl/slr_lap_cell.sv */
// One stage of the lap shift line: holds one recorded lap.
// Depends on slr_pkg for the lap entry type.
module slr_lap_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  slr_pkg::lap_entry_t entry_in,
    output slr_pkg::lap_entry_t entry_out
);

    slr_pkg::lap_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule

/* rtl/stopwatch_lap_recorder.sv */
// Top level of the stopwatch lap recorder: command decode, timer state,
// lap shift line of slr_lap_cell stages and the result register. Uses slr_pkg.
//
// Usage:
//   s_valid/s_ready/s_item carry one command per transfer: kind, the current
//   free-running tick stamp now_ticks and lap_back, the lap to report.
//   m_valid/m_ready/m_item carry one result per command: mode after the
//   command, elapsed ticks at now_ticks, lap count and the requested lap.
//   The result of a command accepted at one edge is shown in the result
//   register from the next cycle on.
//   Throughput is one command per cycle while the receiver does not stall;
//   the state update and the lap lookup both settle in the cycle of the transfer.
//   Laps live in a shift line of LAP_SLOTS cells; newest lap sits in cell 0,
//   so lap_back picks the cell directly.
//   When the receiver stalls, the result register holds its item and
//   s_ready stays high only if that item is taken in the same cycle.
//   Reset (aresetn low, synchronous) clears the mode, stamps, lap count and
//   the result valid; lap cells are not cleared, the lap count gates them.
module stopwatch_lap_recorder #(
    parameter int LAP_SLOTS = slr_pkg::LAP_SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slr_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output slr_pkg::out_item_t m_item
);

    slr_pkg::mode_t      mode_reg, mode_next;
    logic [31:0]         start_reg, start_next;
    logic [31:0]         acc_reg, acc_next;
    logic [15:0]         lap_total_reg, lap_total_next;
    logic                m_valid_reg, m_valid_next;
    slr_pkg::out_item_t  m_item_reg, m_item_next;

    logic                accept;
    logic                do_lap;
    logic [31:0]         elapsed_now;
    logic [31:0]         elapsed_after;
    logic                lap_in_reach;
    slr_pkg::lap_entry_t new_entry;
    slr_pkg::lap_entry_t sel_entry;

    slr_pkg::lap_entry_t chain_in  [LAP_SLOTS];
    slr_pkg::lap_entry_t chain_out [LAP_SLOTS];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign do_lap  = accept && (s_item.kind == slr_pkg::KIND_LAP);

    // mode transitions
    always_comb begin
        mode_next = mode_reg;
        case (s_item.kind)
            slr_pkg::KIND_START: mode_next = slr_pkg::MODE_RUNNING;
            slr_pkg::KIND_PAUSE: mode_next = slr_pkg::MODE_PAUSED;
            slr_pkg::KIND_CLEAR: mode_next = slr_pkg::MODE_CLEARED;
            default:             mode_next = mode_reg;
        endcase
    end

    // timer and lap count updates
    always_comb begin
        elapsed_now = (mode_reg == slr_pkg::MODE_RUNNING) ?
                      acc_reg + (s_item.now_ticks - start_reg) : acc_reg;
        start_next     = start_reg;
        acc_next       = acc_reg;
        lap_total_next = lap_total_reg;
        case (s_item.kind)
            slr_pkg::KIND_START: start_next = s_item.now_ticks;
            slr_pkg::KIND_PAUSE: acc_next = elapsed_now;
            slr_pkg::KIND_CLEAR: begin
                acc_next       = '0;
                lap_total_next = '0;
            end
            slr_pkg::KIND_LAP: begin
                if (lap_total_reg != slr_pkg::LAP_COUNT_MAX) begin
                    lap_total_next = lap_total_reg + 16'd1;
                end
            end
            default: ;
        endcase
        elapsed_after = (mode_next == slr_pkg::MODE_RUNNING) ?
                        acc_next + (s_item.now_ticks - start_next) : acc_next;
        new_entry.lap_time   = elapsed_now;
        new_entry.lap_number = lap_total_next;
    end

    // lap shift line
    assign chain_in[0] = new_entry;
    for (genvar g = 0; g < LAP_SLOTS; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign chain_in[g] = chain_out[g-1];
        end
        slr_lap_cell u_cell (
            .aclk      (aclk),
            .shift_en  (do_lap),
            .entry_in  (chain_in[g]),
            .entry_out (chain_out[g])
        );
    end

    // lookup sees the line as it stands after this command
    always_comb begin
        sel_entry = '0;
        for (int i = 0; i < LAP_SLOTS; i++) begin
            if (8'(i) == s_item.lap_back) begin
                sel_entry = do_lap ? chain_in[i] : chain_out[i];
            end
        end
    end

    assign lap_in_reach = ({1'b0, s_item.lap_back} < 9'(LAP_SLOTS)) &&
                          ({8'd0, s_item.lap_back} < lap_total_next);

    always_comb begin
        m_item_next.run_state     = mode_next;
        m_item_next.elapsed       = elapsed_after;
        m_item_next.laps_recorded = lap_total_next;
        m_item_next.lap_valid     = lap_in_reach;
        m_item_next.lap_number    = lap_in_reach ? sel_entry.lap_number : '0;
        m_item_next.lap_time      = lap_in_reach ? sel_entry.lap_time : '0;
        m_valid_next = accept || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= slr_pkg::MODE_CLEARED;
            start_reg     <= '0;
            acc_reg       <= '0;
            lap_total_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                mode_reg      <= mode_next;
                start_reg     <= start_next;
                acc_reg       <= acc_next;
                lap_total_reg <= lap_total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* rtl/slr_checker.sv */
// Port-level checks for stopwatch_lap_recorder, attached by bind.
// Depends on slr_pkg and the top level's port list.
module slr_assertions (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input slr_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input slr_pkg::out_item_t m_item
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // empty output stage never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output stage");

    // a clear transfer yields a zeroed result next cycle
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.kind == slr_pkg::KIND_CLEAR |=>
        m_valid && m_item.run_state == slr_pkg::MODE_CLEARED &&
        m_item.elapsed == 32'd0 && m_item.laps_recorded == 16'd0 &&
        !m_item.lap_valid)
        else $error("clear result not zeroed");

    // missing lap reports zeros
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.lap_valid |->
        m_item.lap_number == 16'd0 && m_item.lap_time == 32'd0)
        else $error("invalid lap carries data");

    // a reported lap has an ordinal no larger than the count
    a_lap_ordinal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.lap_valid |->
        m_item.lap_number != 16'd0 && m_item.lap_number <= m_item.laps_recorded)
        else $error("lap ordinal out of range");

endmodule

bind stopwatch_lap_recorder slr_assertions u_slr_assertions (.*);

/* tb/slr_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the stopwatch lap recorder: watches both channels, predicts
// each result from the accepted commands and compares. Depends on slr_pkg.
module slr_checker #(
    parameter int LAP_SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  slr_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  slr_pkg::out_item_t m_item,
    output int                 fail_count,
    output int                 results_owed
);
    import slr_pkg::*;

    // predicted stopwatch state
    mode_t       sw_mode;
    logic [31:0] start_q;
    logic [31:0] accum_q;
    lap_entry_t  lap_ring [LAP_SLOTS];
    logic [15:0] lap_count;
    int          wr_slot;

    out_item_t   status_due[$];

    function automatic logic [31:0] elapsed_at(input logic [31:0] now);
        if (sw_mode == MODE_RUNNING)
            return accum_q + (now - start_q);
        return accum_q;
    endfunction

    function automatic out_item_t stopwatch_step(input in_item_t cmd);
        out_item_t   r;
        logic [15:0] ordinal;
        int          idx;
        r = '0;
        case (cmd.kind)
            KIND_START: begin
                sw_mode = MODE_RUNNING;
                start_q = cmd.now_ticks;
            end
            KIND_PAUSE: begin
                // only a running watch folds the open interval in
                if (sw_mode == MODE_RUNNING)
                    accum_q = accum_q + (cmd.now_ticks - start_q);
                sw_mode = MODE_PAUSED;
            end
            KIND_CLEAR: begin
                sw_mode   = MODE_CLEARED;
                accum_q   = '0;
                lap_count = '0;
                wr_slot   = 0;
            end
            KIND_LAP: begin
                ordinal = (lap_count == LAP_COUNT_MAX) ? LAP_COUNT_MAX : lap_count + 16'd1;
                lap_ring[wr_slot].lap_time   = elapsed_at(cmd.now_ticks);
                lap_ring[wr_slot].lap_number = ordinal;
                lap_count = ordinal;
                wr_slot   = (wr_slot + 1) % LAP_SLOTS;
            end
            default: ;  // read only, spare codes included
        endcase
        r.run_state     = sw_mode;
        r.elapsed       = elapsed_at(cmd.now_ticks);
        r.laps_recorded = lap_count;
        if (int'(cmd.lap_back) < LAP_SLOTS && {8'd0, cmd.lap_back} < lap_count) begin
            idx = (wr_slot + LAP_SLOTS - 1 - int'(cmd.lap_back)) % LAP_SLOTS;
            r.lap_valid  = 1'b1;
            r.lap_number = lap_ring[idx].lap_number;
            r.lap_time   = lap_ring[idx].lap_time;
        end
        return r;
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, fname, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t due;
        if (!aresetn) begin
            sw_mode   = MODE_CLEARED;
            start_q   = '0;
            accum_q   = '0;
            lap_count = '0;
            wr_slot   = 0;
            status_due.delete();
        end else begin
            // pop before push: a result never belongs to the command of the same edge
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: expected none, got 0x%0h",
                             $time, m_item);
                    fail_count++;
                end else begin
                    due = status_due.pop_front();
                    compare_field("run_state", 32'(due.run_state), 32'(m_item.run_state));
                    compare_field("elapsed", due.elapsed, m_item.elapsed);
                    compare_field("laps_recorded", 32'(due.laps_recorded),
                                  32'(m_item.laps_recorded));
                    compare_field("lap_valid", 32'(due.lap_valid), 32'(m_item.lap_valid));
                    compare_field("lap_number", 32'(due.lap_number), 32'(m_item.lap_number));
                    compare_field("lap_time", due.lap_time, m_item.lap_time);
                end
            end
            if (s_valid && s_ready)
                status_due.push_back(stopwatch_step(s_item));
        end
        results_owed <= status_due.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the stopwatch lap recorder bench: clock, reset, command stimulus,
// receiver throttling and the verdict. Depends on slr_pkg and slr_checker.
module tb_top;
    import slr_pkg::*;

    localparam int          LAP_SLOTS      = 16;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          LAP_BURST      = 40;
    localparam int          RANDOM_ITEMS   = 880;
    localparam logic [2:0]  KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    int         fail_count;
    int         results_owed;
    logic       tx_throttle = 1'b0;
    logic       rx_throttle = 1'b0;
    int         rx_stall_left = 0;
    int         idle_cycles = 0;
    logic [31:0] tick = '0;

    stopwatch_lap_recorder #(.LAP_SLOTS(LAP_SLOTS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    slr_checker #(.LAP_SLOTS(LAP_SLOTS)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .fail_count(fail_count), .results_owed(results_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t make_cmd(input logic [2:0] kind, input logic [31:0] now,
                                          input logic [7:0] back);
        in_item_t c;
        c.kind      = kind;
        c.now_ticks = now;
        c.lap_back  = back;
        return c;
    endfunction

    task automatic send_cmd(input in_item_t cmd);
        int gap;
        gap = tx_throttle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    // random command on a mostly forward-moving timeline
    function automatic in_item_t random_cmd();
        int          r;
        logic [2:0]  kind;
        logic [7:0]  back;
        r = $urandom_range(0, 99);
        if (r < 90)
            tick = tick + $urandom_range(0, 300);
        else if (r < 97)
            tick = $urandom;
        else
            tick = tick - $urandom_range(1, 50);
        r = $urandom_range(0, 99);
        if (r < 14)
            kind = KIND_START;
        else if (r < 26)
            kind = KIND_PAUSE;
        else if (r < 30)
            kind = KIND_CLEAR;
        else if (r < 70)
            kind = KIND_LAP;
        else if (r < 94)
            kind = KIND_READ;
        else
            kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        back = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 17)) : 8'($urandom);
        return make_cmd(kind, tick, back);
    endfunction

    always @(posedge aclk) begin
        int g;
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_throttle) begin
            g = pick_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                rx_stall_left = g - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stopwatch_lap_recorder verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int k;
        int phase;
        repeat (8) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_throttle <= 1'b1;
        rx_throttle <= 1'b1;
        @(posedge aclk);

        // directed: wraps, restart, pause from every mode, spare codes, clear
        send_cmd(make_cmd(KIND_READ,  32'h0000_0000, 8'd0));
        send_cmd(make_cmd(KIND_PAUSE, 32'h0000_0005, 8'd255));
        send_cmd(make_cmd(KIND_START, 32'hFFFF_FFF0, 8'd0));
        send_cmd(make_cmd(KIND_READ,  32'h0000_0010, 8'd0));
        send_cmd(make_cmd(KIND_LAP,   32'h0000_0020, 8'd0));
        send_cmd(make_cmd(KIND_START, 32'h0000_0100, 8'd1));
        send_cmd(make_cmd(KIND_LAP,   32'h0000_0180, 8'd1));
        send_cmd(make_cmd(KIND_PAUSE, 32'h0000_0200, 8'd1));
        send_cmd(make_cmd(KIND_PAUSE, 32'h0000_0900, 8'd0));
        send_cmd(make_cmd(KIND_LAP,   32'h0000_0A00, 8'd2));
        send_cmd(make_cmd(KIND_READ,  32'hFFFF_FFFF, 8'd3));
        for (k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_cmd(make_cmd(3'(k), 32'h1234_5678, 8'd0));
        send_cmd(make_cmd(KIND_START, 32'hFFFF_FFFF, 8'd255));
        send_cmd(make_cmd(KIND_PAUSE, 32'h0000_0000, 8'd0));
        send_cmd(make_cmd(KIND_CLEAR, 32'hAAAA_5555, 8'd0));
        send_cmd(make_cmd(KIND_READ,  32'h5555_AAAA, 8'd0));
        send_cmd(make_cmd(KIND_LAP,   32'h8000_0000, 8'd0));
        send_cmd(make_cmd(KIND_START, 32'h7FFF_FFFF, 8'd128));
        send_cmd(make_cmd(KIND_CLEAR, 32'h0000_0001, 8'd0));
        send_cmd(make_cmd(KIND_PAUSE, 32'h0000_0002, 8'd0));
        drain();

        // back-to-back laps, the ring wraps twice
        tx_throttle <= 1'b0;
        rx_throttle <= 1'b0;
        tick = $urandom;
        send_cmd(make_cmd(KIND_START, tick, 8'd0));
        for (k = 0; k < LAP_BURST; k++) begin
            tick = tick + $urandom_range(1, 1000);
            send_cmd(make_cmd(KIND_LAP, tick, 8'($urandom)));
        end
        send_cmd(make_cmd(KIND_READ,  tick + 32'd7, 8'd15));
        send_cmd(make_cmd(KIND_READ,  tick + 32'd9, 8'd16));
        send_cmd(make_cmd(KIND_PAUSE, tick + 32'd11, 8'd0));
        send_cmd(make_cmd(KIND_LAP,   tick + 32'd13, 8'd0));
        send_cmd(make_cmd(KIND_CLEAR, tick + 32'd15, 8'd0));
        send_cmd(make_cmd(KIND_LAP,   tick + 32'd17, 8'd0));
        drain();

        // random phases with different throttling, each drained before the next
        for (phase = 0; phase < 4; phase++) begin
            tx_throttle <= (phase == 0 || phase == 2);
            rx_throttle <= (phase == 0 || phase == 3);
            for (k = 0; k < RANDOM_ITEMS / 4; k++)
                send_cmd(random_cmd());
            drain();
        end

        repeat (6) @(posedge aclk);
        if (fail_count == 0)
            $display("stopwatch_lap_recorder verification clean");
        else
            $display("stopwatch_lap_recorder verification failed");
        $finish;
    end

endmodule
